### src/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
`default_nettype none

package rmq_pkg;

    localparam int unsigned Q_ONE  = 16384;
    localparam logic [1:0] ARM_LEFT  = 2'd0;
    localparam logic [1:0] ARM_RIGHT = 2'd1;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } t_branch;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_mat_in;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic               ok;
    } t_quat_out;

    // Travels alongside the square root: branch, validity and the three
    // numerators in ascending component order, skipping the branch's own.
    typedef struct packed {
        logic               ok;
        t_branch            br;
        logic signed [16:0] num0;
        logic signed [16:0] num1;
        logic signed [16:0] num2;
    } t_side;

endpackage

`default_nettype wire

### src/rmq_sqrt.sv
// Pipelined restoring integer square root, one root bit per stage.
`default_nettype none

module rmq_sqrt (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [16:0]   i_arg,
    input  wire rmq_pkg::t_side i_side,
    output logic               o_valid,
    output logic [15:0]        o_root,
    output rmq_pkg::t_side     o_side
);
    import rmq_pkg::*;

    localparam int NS = 16;

    logic [NS:0]  r_vld;
    logic [31:0]  r_x    [0:NS];
    logic [17:0]  r_rem  [0:NS];
    logic [15:0]  r_root [0:NS];
    t_side        r_side [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_x[0]    <= {1'b0, i_arg, 14'b0};
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_side[0] <= i_side;
    end

    for (genvar k = 1; k <= NS; k++) begin : g_stage
        logic [19:0] n_sh;
        logic [19:0] n_trial;
        logic        n_ge;
        assign n_sh    = {r_rem[k-1], r_x[k-1][31:30]};
        assign n_trial = {2'b00, r_root[k-1], 2'b01};
        assign n_ge    = (n_sh >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
            r_x[k]    <= {r_x[k-1][29:0], 2'b00};
            r_rem[k]  <= n_ge ? 18'(n_sh - n_trial) : n_sh[17:0];
            r_root[k] <= {r_root[k-1][14:0], n_ge};
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_valid = r_vld[NS];
    assign o_root  = r_root[NS];
    assign o_side  = r_side[NS];

endmodule

`default_nettype wire

### src/rmq_div.sv
// Pipelined rounding divider num / (2*root) with saturation to one.
`default_nettype none

module rmq_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic signed [16:0]  i_num,
    input  wire logic [15:0]         i_root,
    output logic                     o_valid,
    output logic signed [15:0]       o_quo
);
    import rmq_pkg::*;

    localparam int NB = 15;

    logic [16:0] n_mag;
    logic [31:0] n_n;
    logic [16:0] n_s;
    logic [32:0] n_lim;

    assign n_mag = i_num[16] ? 17'(-i_num) : 17'(i_num);
    assign n_n   = {1'b0, n_mag, 14'b0} + {16'b0, i_root};
    assign n_s   = {i_root, 1'b0};
    assign n_lim = {2'b00, n_s, 14'b0} + {16'b0, n_s};

    logic [NB:0]  r_vld;
    logic [31:0]  r_rem  [0:NB];
    logic [16:0]  r_s    [0:NB];
    logic [14:0]  r_q    [0:NB];
    logic [NB:0]  r_neg;
    logic [NB:0]  r_sat;
    logic [NB:0]  r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_rem[0]  <= n_n;
        r_s[0]    <= n_s;
        r_q[0]    <= '0;
        r_neg[0]  <= i_num[16];
        r_sat[0]  <= ({1'b0, n_n} >= n_lim);
        r_zero[0] <= (i_root == '0);
    end

    for (genvar k = 1; k <= NB; k++) begin : g_stage
        localparam int SH = NB - k;
        logic [31:0] n_sub;
        logic        n_ge;
        assign n_sub = {15'b0, r_s[k-1]} << SH;
        assign n_ge  = (r_rem[k-1] >= n_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
            r_rem[k]  <= n_ge ? (r_rem[k-1] - n_sub) : r_rem[k-1];
            r_s[k]    <= r_s[k-1];
            r_q[k]    <= {r_q[k-1][13:0], n_ge};
            r_neg[k]  <= r_neg[k-1];
            r_sat[k]  <= r_sat[k-1];
            r_zero[k] <= r_zero[k-1];
        end
    end

    logic [15:0] n_qmag;
    always_comb begin
        if (r_zero[NB]) begin
            n_qmag = '0;
        end else if (r_sat[NB]) begin
            n_qmag = 16'(Q_ONE);
        end else begin
            n_qmag = {1'b0, r_q[NB]};
        end
    end

    assign o_valid = r_vld[NB];
    assign o_quo   = r_neg[NB] ? 16'(-n_qmag) : n_qmag;

endmodule

`default_nettype wire

### src/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to unit quaternion, Shepperd four-branch method.
//
//  Channel   Direction  Handshake               Payload
//  command   in         start, busy             i_mat (nine Q1.14 entries)
//  result    out        o_done (one-cycle)      o_quat (w, x, y, z, ok)
//  config    in         i_cfg_we                i_cfg_data (arm select)
//
// One transaction enters per clock; busy is always low. Each result passes
// through one front stage that picks the branch, 17 for the square root (one
// root bit per stage), 16 for the three parallel dividers (one quotient bit per
// stage) and one output register.
// Reset (synchronous, active low) clears all valid bits and the arm select.
// The receiver cannot stall, so the pipeline simply advances every cycle.
`default_nettype none

module rotation_matrix_to_quaternion (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire rmq_pkg::t_mat_in i_mat,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_data,
    output logic                o_done,
    output rmq_pkg::t_quat_out  o_quat
);
    import rmq_pkg::*;

    localparam int TAIL = 16;

    typedef struct packed {
        logic               ok;
        t_branch            br;
        logic signed [15:0] own;
    } t_tail;

    // The command is never refused.
    assign busy = 1'b0;

    logic [1:0] r_arm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm <= ARM_LEFT;
        end else if (i_cfg_we) begin
            r_arm <= i_cfg_data;
        end
    end

    // Front stage: trace, branch choice, square root argument, numerators.
    logic signed [18:0] n_a00, n_a01, n_a02, n_a10, n_a11, n_a12, n_a20, n_a21, n_a22;
    logic signed [18:0] n_tr, n_arg;
    t_side              n_side;

    assign n_a00 = 19'(i_mat.m00);
    assign n_a01 = 19'(i_mat.m01);
    assign n_a02 = 19'(i_mat.m02);
    assign n_a10 = 19'(i_mat.m10);
    assign n_a11 = 19'(i_mat.m11);
    assign n_a12 = 19'(i_mat.m12);
    assign n_a20 = 19'(i_mat.m20);
    assign n_a21 = 19'(i_mat.m21);
    assign n_a22 = 19'(i_mat.m22);
    assign n_tr  = n_a00 + n_a11 + n_a22;

    always_comb begin
        n_side.ok = (r_arm == ARM_LEFT) || (r_arm == ARM_RIGHT);
        if (n_tr > 0) begin
            n_side.br   = BR_W;
            n_arg       = 19'(Q_ONE) + n_tr;
            n_side.num0 = 17'(n_a21 - n_a12);
            n_side.num1 = 17'(n_a02 - n_a20);
            n_side.num2 = 17'(n_a10 - n_a01);
        end else if (n_a00 > n_a11 && n_a00 > n_a22) begin
            n_side.br   = BR_X;
            n_arg       = 19'(Q_ONE) + n_a00 - n_a11 - n_a22;
            n_side.num0 = 17'(n_a21 - n_a12);
            n_side.num1 = 17'(n_a01 + n_a10);
            n_side.num2 = 17'(n_a02 + n_a20);
        end else if (n_a11 > n_a22) begin
            n_side.br   = BR_Y;
            n_arg       = 19'(Q_ONE) + n_a11 - n_a00 - n_a22;
            n_side.num0 = 17'(n_a02 - n_a20);
            n_side.num1 = 17'(n_a01 + n_a10);
            n_side.num2 = 17'(n_a12 + n_a21);
        end else begin
            n_side.br   = BR_Z;
            n_arg       = 19'(Q_ONE) + n_a22 - n_a00 - n_a11;
            n_side.num0 = 17'(n_a10 - n_a01);
            n_side.num1 = 17'(n_a02 + n_a20);
            n_side.num2 = 17'(n_a12 + n_a21);
        end
    end

    logic        r_f_vld;
    logic [16:0] r_f_arg;
    t_side       r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= start;
        end
        // A negative argument is clamped to zero.
        r_f_arg  <= n_arg[18] ? '0 : n_arg[16:0];
        r_f_side <= n_side;
    end

    logic        s_vld;
    logic [15:0] s_root;
    t_side       s_side;

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_vld),
        .i_arg   (r_f_arg),
        .i_side  (r_f_side),
        .o_valid (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // The branch's own component is root / 2, saturated to one.
    t_tail n_tail;
    always_comb begin
        n_tail.ok  = s_side.ok;
        n_tail.br  = s_side.br;
        n_tail.own = (s_root[15:1] > 15'(Q_ONE)) ? 16'(Q_ONE) : {1'b0, s_root[15:1]};
    end

    t_tail r_tail [0:TAIL-1];
    always_ff @(posedge i_clk) begin
        r_tail[0] <= n_tail;
        for (int i = 1; i < TAIL; i++) begin
            r_tail[i] <= r_tail[i-1];
        end
    end

    logic               d_vld0, d_vld1, d_vld2;
    logic signed [15:0] d_q0, d_q1, d_q2;

    rmq_div u_div0 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (s_vld),
        .i_num (s_side.num0), .i_root (s_root), .o_valid (d_vld0), .o_quo (d_q0)
    );
    rmq_div u_div1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (s_vld),
        .i_num (s_side.num1), .i_root (s_root), .o_valid (d_vld1), .o_quo (d_q1)
    );
    rmq_div u_div2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (s_vld),
        .i_num (s_side.num2), .i_root (s_root), .o_valid (d_vld2), .o_quo (d_q2)
    );

    // Place the quotients around the branch's own component.
    t_quat_out n_quat;
    t_tail     n_last;
    assign n_last = r_tail[TAIL-1];

    always_comb begin
        n_quat.ok = n_last.ok;
        case (n_last.br)
            BR_W: begin
                n_quat.quat_w = n_last.own; n_quat.quat_x = d_q0;
                n_quat.quat_y = d_q1;       n_quat.quat_z = d_q2;
            end
            BR_X: begin
                n_quat.quat_w = d_q0;       n_quat.quat_x = n_last.own;
                n_quat.quat_y = d_q1;       n_quat.quat_z = d_q2;
            end
            BR_Y: begin
                n_quat.quat_w = d_q0;       n_quat.quat_x = d_q1;
                n_quat.quat_y = n_last.own; n_quat.quat_z = d_q2;
            end
            default: begin
                n_quat.quat_w = d_q0;       n_quat.quat_x = d_q1;
                n_quat.quat_y = d_q2;       n_quat.quat_z = n_last.own;
            end
        endcase
        // An invalid arm select yields an all-zero result.
        if (!n_last.ok) begin
            n_quat = '0;
        end
    end

    logic r_done;
    t_quat_out r_quat;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d_vld0 & d_vld1 & d_vld2;
        end
        r_quat <= n_quat;
    end

    assign o_done = r_done;
    assign o_quat = r_quat;

endmodule

`default_nettype wire
